[hdl/fsla_pkg.sv]
package fsla_pkg;

  localparam int MAX_SLOTS_DEF = 256;

  localparam int COUNT_W    = 9;
  localparam int BYTES_W    = 13;
  localparam int OFFSET_W   = 21;
  localparam int INDEX_W    = 8;
  localparam int SLOT_OFF_W = 20;
  localparam int USED_W     = 9;
  localparam int STATUS_W   = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 40;

  // dividend of the free path: the non-negative part of the offset
  localparam int DVD_W  = SLOT_OFF_W;
  localparam int PROD_W = COUNT_W + BYTES_W;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [BYTES_W-1:0] BYTES_RESET = 13'd4;
  localparam logic [BYTES_W-1:0] MIN_BYTES   = 13'd4;
  localparam logic [BYTES_W-1:0] MAX_BYTES   = 13'd4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_ALIGN = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT = 1'b0,
    REG_SLOT_BYTES = 1'b1
  } cfg_reg_t;

endpackage

[hdl/fsla_div.sv]
module fsla_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fsla_pkg::DVD_W-1:0]   dividend,
  input  logic [fsla_pkg::BYTES_W-1:0] divisor,
  output logic                         done,
  output logic [fsla_pkg::DVD_W-1:0]   quot,
  output logic [fsla_pkg::BYTES_W-1:0] rem
);
  import fsla_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [DVD_W-1:0]   dvd;
  logic [BYTES_W-1:0] dvs;
  logic [BYTES_W-1:0] part;
  logic [BYTES_W:0]   part_sh;
  logic [BYTES_W:0]   diff;
  logic               ge;
  logic               last_step;

  // one quotient bit per cycle, quotient shifts into the dividend register
  assign part_sh   = {part, dvd[DVD_W-1]};
  assign diff      = part_sh - {1'b0, dvs};
  assign ge        = part_sh >= {1'b0, dvs};
  assign quot      = dvd;
  assign rem       = part;
  assign last_step = (cnt == CNT_W'(DVD_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && last_step;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (last_step) begin
          busy <= 1'b0;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= dividend;
      dvs  <= divisor;
      part <= '0;
    end else if (busy) begin
      dvd  <= {dvd[DVD_W-2:0], ge};
      part <= ge ? diff[BYTES_W-1:0] : part_sh[BYTES_W-1:0];
    end
  end

endmodule

[hdl/fsla_mul.sv]
module fsla_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fsla_pkg::COUNT_W-1:0] mcand,
  input  logic [fsla_pkg::BYTES_W-1:0] mplier,
  output logic                         done,
  output logic [fsla_pkg::PROD_W-1:0]  prod
);
  import fsla_pkg::*;

  localparam int CNT_W = $clog2(COUNT_W);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [COUNT_W-1:0] a_sh;
  logic [BYTES_W-1:0] b;
  logic [PROD_W-1:0]  acc;
  logic               last_step;

  // msb first shift-add, one multiplicand bit per cycle
  assign prod      = acc;
  assign last_step = (cnt == CNT_W'(COUNT_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !start && last_step;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (last_step) begin
          busy <= 1'b0;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= mcand;
      b    <= mplier;
      acc  <= '0;
    end else if (busy) begin
      a_sh <= {a_sh[COUNT_W-2:0], 1'b0};
      acc  <= {acc[PROD_W-2:0], 1'b0} + (a_sh[COUNT_W-1] ? PROD_W'(b) : '0);
    end
  end

endmodule

[hdl/fixed_slot_free_list_allocator.sv]
// Fixed-size slot pool with a LIFO free list.
// Requests enter on the s_ channel: s_tuser is the mode (0 allocate, 1 free)
// and s_tdata carries the signed byte offset of the slot to free.
// Each request gives exactly one result on the m_ channel: m_tuser is the
// status, m_tdata carries slot index, slot byte offset and used count.
// Capacity and slot size are set through the cfg_ write port; a slot_count
// write rebuilds the free chain and clears the used count.
// One request is worked at a time. Allocate forms the slot offset with the
// 9-step shift-add multiplier; free splits the offset into index and
// remainder with the 20-step restoring divider. Errors that need no
// arithmetic (empty pool, negative offset) go straight to the result.
// After reset, and after each slot_count write, the link store is refilled
// one entry per cycle for slot_count entries; s_tready stays low meanwhile.
// A finished result waits in the output register while the receiver stalls;
// the next request is taken in the meantime and held until the output frees.
module fixed_slot_free_list_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fsla_pkg::S_TDATA_W-1:0]  s_tdata,   // byte_offset
  input  logic                            s_tuser,   // mode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fsla_pkg::M_TDATA_W-1:0]  m_tdata,   // slot_index, slot_offset, used_count
  output logic [fsla_pkg::STATUS_W-1:0]   m_tuser,   // status
  input  logic                            cfg_we,
  input  logic [fsla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsla_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fsla_pkg::*;

  localparam int MAX_SLOTS = MAX_SLOTS_DEF;
  localparam int LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W = $clog2(MAX_SLOTS);
  localparam logic [LINK_W-1:0]  END_MARK   = LINK_W'(MAX_SLOTS);
  localparam logic [COUNT_W-1:0] COUNT_INIT =
    (MAX_SLOTS < int'(COUNT_RESET)) ? COUNT_W'(MAX_SLOTS) : COUNT_RESET;

  typedef enum logic [2:0] {
    S_FILL,
    S_IDLE,
    S_ALLOC,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  logic [COUNT_W-1:0]    slot_count;
  logic [BYTES_W-1:0]    slot_bytes;
  logic [LINK_W-1:0]     head_ptr;
  logic [LINK_W-1:0]     fill_cnt;
  logic [USED_W-1:0]     in_use;
  logic [SLOT_OFF_W-1:0] req_off;
  logic [INDEX_W-1:0]    alloc_idx;

  status_t               res_status;
  logic [INDEX_W-1:0]    res_idx;
  logic [SLOT_OFF_W-1:0] res_off;
  logic [USED_W-1:0]     res_used;

  status_t               out_status;
  logic [INDEX_W-1:0]    out_idx;
  logic [SLOT_OFF_W-1:0] out_off;
  logic [USED_W-1:0]     out_used;

  logic [LINK_W-1:0] link_mem [MAX_SLOTS];
  logic [LINK_W-1:0] rd_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic                  accept;
  logic                  head_empty;
  logic                  div_start;
  logic                  div_done;
  logic [DVD_W-1:0]      quot;
  logic [BYTES_W-1:0]    rem;
  logic                  quot_range;
  logic                  free_ok;
  logic                  mul_start;
  logic                  mul_done;
  logic [PROD_W-1:0]     prod;
  logic [USED_W-1:0]     in_use_inc;
  logic [USED_W-1:0]     in_use_dec;
  logic [LINK_W-1:0]     head_next;
  logic [COUNT_W-1:0]    count_in;
  logic [COUNT_W-1:0]    count_clamped;
  logic [BYTES_W-1:0]    bytes_in;
  logic [BYTES_W-1:0]    bytes_clamped;
  logic                  out_load;
  logic                  count_we;
  logic                  bytes_we;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign head_empty = 32'(head_ptr) >= 32'(slot_count);
  assign div_start  = accept && s_tuser && !s_tdata[OFFSET_W-1];
  assign mul_start  = accept && !s_tuser && !head_empty;
  assign quot_range = quot >= DVD_W'(slot_count);
  assign free_ok    = (state == S_DIV) && div_done && !quot_range && (rem == '0);
  assign in_use_inc = (in_use < USED_W'(slot_count)) ? in_use + USED_W'(1) : in_use;
  assign in_use_dec = (in_use != '0) ? in_use - USED_W'(1) : in_use;
  assign head_next  = (32'(rd_data) < 32'(slot_count)) ? rd_data : END_MARK;
  assign out_load   = (state == S_DONE) && (!m_tvalid || m_tready);
  assign count_we   = cfg_we && (cfg_index == REG_SLOT_COUNT);
  assign bytes_we   = cfg_we && (cfg_index == REG_SLOT_BYTES);

  assign m_tuser = out_status;
  assign m_tdata = {3'b000, out_used, out_off, out_idx};

  always_comb begin
    count_in = cfg_data[COUNT_W-1:0];
    bytes_in = cfg_data[BYTES_W-1:0];
    if (count_in == '0) begin
      count_clamped = COUNT_W'(1);
    end else if (32'(count_in) > MAX_SLOTS) begin
      count_clamped = COUNT_W'(MAX_SLOTS);
    end else begin
      count_clamped = count_in;
    end
    if (bytes_in < MIN_BYTES) begin
      bytes_clamped = MIN_BYTES;
    end else if (bytes_in > MAX_BYTES) begin
      bytes_clamped = MAX_BYTES;
    end else begin
      bytes_clamped = bytes_in;
    end
  end

  // link store ports: refill pass and free push share the write port
  always_comb begin
    mem_we    = (state == S_FILL) || free_ok;
    mem_waddr = (state == S_FILL) ? fill_cnt[ADDR_W-1:0] : quot[ADDR_W-1:0];
    mem_wdata = (state == S_FILL) ? fill_cnt + LINK_W'(1) : head_ptr;
    mem_re    = mul_start;
    mem_raddr = head_ptr[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= link_mem[mem_raddr];
    end
  end

  fsla_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_tdata[DVD_W-1:0]),
    .divisor  (slot_bytes),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  fsla_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .mcand  (COUNT_W'(head_ptr)),
    .mplier (slot_bytes),
    .done   (mul_done),
    .prod   (prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_cnt   <= '0;
      head_ptr   <= '0;
      in_use     <= '0;
      slot_count <= COUNT_INIT;
      slot_bytes <= BYTES_RESET;
      m_tvalid   <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      if (out_load) begin
        out_status <= res_status;
        out_idx    <= res_idx;
        out_off    <= res_off;
        out_used   <= res_used;
      end
      if (bytes_we) begin
        slot_bytes <= bytes_clamped;
      end
      if (count_we) begin
        slot_count <= count_clamped;
        head_ptr   <= '0;
        in_use     <= '0;
        fill_cnt   <= '0;
        state      <= S_FILL;
      end else begin
        unique case (state)
          S_FILL: begin
            fill_cnt <= fill_cnt + LINK_W'(1);
            if (32'(fill_cnt) + 1 >= 32'(slot_count)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (accept) begin
              req_off   <= s_tdata[SLOT_OFF_W-1:0];
              alloc_idx <= INDEX_W'(head_ptr);
              res_idx   <= '0;
              res_off   <= '0;
              res_used  <= in_use;
              if (!s_tuser) begin
                if (head_empty) begin
                  res_status <= ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  state <= S_ALLOC;
                end
              end else if (s_tdata[OFFSET_W-1]) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                state <= S_DIV;
              end
            end
          end
          S_ALLOC: begin
            if (mul_done) begin
              head_ptr   <= head_next;
              in_use     <= in_use_inc;
              res_status <= ST_OK;
              res_idx    <= alloc_idx;
              res_off    <= prod[SLOT_OFF_W-1:0];
              res_used   <= in_use_inc;
              state      <= S_DONE;
            end
          end
          S_DIV: begin
            if (div_done) begin
              priority if (quot_range) begin
                res_status <= ST_RANGE;
              end else if (rem != '0) begin
                res_status <= ST_ALIGN;
              end else begin
                head_ptr   <= LINK_W'(quot);
                in_use     <= in_use_dec;
                res_status <= ST_OK;
                res_idx    <= quot[INDEX_W-1:0];
                res_off    <= req_off;
                res_used   <= in_use_dec;
              end
              state <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_load) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_FILL;
        endcase
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    in_use <= USED_W'(slot_count))
    else $error("used count above slot count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in work");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (32'(head_ptr) < 32'(slot_count) || head_ptr == END_MARK))
    else $error("free list head names no chained slot");

endmodule
